### rtl/core/mcpd_pkg.sv
// Package for the multi-class priority deque.
// Request codes, status codes, field widths and the control state type.
// No dependencies.
package mcpd_pkg;

	localparam int ID_W   = 16;
	localparam int OP_W   = 2;
	localparam int QSEL_W = 4;
	localparam int ST_W   = 2;
	localparam int POS_W  = 3;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_LIST   = 2'd1,
		OP_TAKE   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RSVD  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_READ = 3'b100
	} state_t;

endpackage

### rtl/core/multi_class_priority_deque.sv
// Multi-class priority deque: QUEUES bounded queues of DEPTH entries each.
// Requests arrive on req_* (valid/stall); results leave on rsp_* (valid/stall).
// op insert: urgent entries go to the front, regular ones to the back; one
//   result, status full if the queue already holds DEPTH entries.
// op take: one result with the front entry, or status empty.
// op list: one result per entry, front first, last set on the final one;
//   an empty queue gives one status empty result. op 3 gives no result.
// Each queue is a ring in the entry RAM; a descriptor RAM holds its head
// slot and fill count. Both RAMs give registered read data. Each request
// first reads its queue's descriptor; take and list then do one entry RAM
// read per returned entry. One request is in work at a time; req_stall is
// high while it is. A stalled result holds in the output register; the
// block waits for it to drain before writing the next result.
// Reset clears the descriptor valid bits, so every queue starts empty; the
// entry RAM is not cleared and needs no sweep.
module multi_class_priority_deque #(
	parameter int QUEUES = 16,
	parameter int DEPTH  = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [mcpd_pkg::OP_W-1:0]  op,
	input  logic [mcpd_pkg::QSEL_W-1:0] queue_sel,
	input  logic [mcpd_pkg::ID_W-1:0]  entry_id,
	input  logic                       urgent,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [mcpd_pkg::ST_W-1:0]  status,
	output logic [mcpd_pkg::ID_W-1:0]  out_id,
	output logic                       out_urgent,
	output logic [mcpd_pkg::POS_W-1:0] position,
	output logic                       last
);
	import mcpd_pkg::*;

	localparam int QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam int PW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int MW  = PW + CW;
	localparam int EW  = ID_W + 1;
	localparam int ED  = QUEUES * (1 << PW);
	localparam int EAW = (ED > 1) ? $clog2(ED) : 1;

	state_t          state_q;
	op_t             op_q;
	logic [QW-1:0]   q_q;
	logic            inrange_q;
	logic [ID_W-1:0] id_q;
	logic            urg_q;
	logic            take_q;
	logic [PW-1:0]   slot_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   n_q;
	logic [QUEUES-1:0] meta_vld_q;

	logic            rsp_valid_q;
	logic [ST_W-1:0] status_q;
	logic [ID_W-1:0] out_id_q;
	logic            out_urgent_q;
	logic [POS_W-1:0] position_q;
	logic            last_q;

	logic            req_acc;
	logic            req_inrange;
	logic            out_free;
	logic [QW-1:0]   req_q;
	logic            exec_read;
	logic            rsp_load;

	// descriptor RAM
	logic            m_we;
	logic [MW-1:0]   m_wdata;
	logic [MW-1:0]   m_rdata;
	logic [PW-1:0]   m_head;
	logic [CW-1:0]   m_cnt;

	// entry RAM
	logic            e_we;
	logic [PW-1:0]   e_wslot;
	logic [EW-1:0]   e_wdata;
	logic            e_re;
	logic [PW-1:0]   e_rslot;
	logic [EW-1:0]   e_rdata;

	logic [PW:0]     tail_sum;
	logic [PW-1:0]   tail_slot;
	logic [PW-1:0]   head_dec;
	logic [PW-1:0]   head_inc;
	logic [PW-1:0]   slot_inc;
	logic            rd_last;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] s);
		wrap_inc = (s == PW'(DEPTH - 1)) ? '0 : s + PW'(1);
	endfunction

	assign req_stall   = (state_q != S_IDLE);
	assign req_acc     = req_valid && !req_stall;
	assign req_inrange = (32'(queue_sel) < QUEUES);
	assign req_q       = QW'(queue_sel);
	assign out_free    = !rsp_valid_q || !rsp_stall;

	assign m_head = meta_vld_q[q_q] ? m_rdata[MW-1:CW] : '0;
	assign m_cnt  = meta_vld_q[q_q] ? m_rdata[CW-1:0] : '0;

	assign tail_sum  = {1'b0, m_head} + (PW+1)'(m_cnt);
	assign tail_slot = (tail_sum >= (PW+1)'(DEPTH)) ?
		PW'(tail_sum - (PW+1)'(DEPTH)) : PW'(tail_sum);
	assign head_dec  = (m_head == '0) ? PW'(DEPTH - 1) : m_head - PW'(1);
	assign head_inc  = wrap_inc(m_head);
	assign slot_inc  = wrap_inc(slot_q);
	assign rd_last   = take_q || (idx_q == n_q - CW'(1));

	// take or list of a non-empty queue goes on to the entry read stage
	assign exec_read = inrange_q && op_q != OP_INSERT && m_cnt != '0;
	assign rsp_load  = out_free &&
		((state_q == S_EXEC && !exec_read) || state_q == S_READ);

	always_comb begin
		m_we    = 1'b0;
		m_wdata = {m_head, m_cnt};
		e_we    = 1'b0;
		e_wslot = tail_slot;
		e_wdata = {urg_q, id_q};
		e_re    = 1'b0;
		e_rslot = m_head;
		if (state_q == S_EXEC && inrange_q) begin
			priority if (op_q == OP_INSERT) begin
				if (m_cnt != CW'(DEPTH) && out_free) begin
					m_we    = 1'b1;
					e_we    = 1'b1;
					e_wslot = urg_q ? head_dec : tail_slot;
					m_wdata = {urg_q ? head_dec : m_head, m_cnt + CW'(1)};
				end
			end else if (m_cnt != '0) begin
				e_re = 1'b1;
				if (op_q == OP_TAKE) begin
					m_we    = 1'b1;
					m_wdata = {head_inc, m_cnt - CW'(1)};
				end
			end
		end else if (state_q == S_READ && out_free && !rd_last) begin
			e_re    = 1'b1;
			e_rslot = slot_inc;
		end
	end

	mcpd_ram #(
		.WIDTH (MW),
		.DEPTH (QUEUES)
	) u_meta_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (q_q),
		.wdata (m_wdata),
		.re    (req_acc && req_inrange),
		.raddr (req_q),
		.rdata (m_rdata)
	);

	mcpd_ram #(
		.WIDTH (EW),
		.DEPTH (ED)
	) u_entry_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (EAW'({q_q, e_wslot})),
		.wdata (e_wdata),
		.re    (e_re),
		.raddr (EAW'({q_q, e_rslot})),
		.rdata (e_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			meta_vld_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= rsp_load || (rsp_valid_q && rsp_stall);
			if (m_we) begin
				meta_vld_q[q_q] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc && op_t'(op) != OP_NONE) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_read) begin
						state_q <= S_READ;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					if (out_free && rd_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request capture, list walk and result payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q      <= op_t'(op);
			q_q       <= req_q;
			inrange_q <= req_inrange;
			id_q      <= entry_id;
			urg_q     <= urgent;
		end
		if (state_q == S_EXEC) begin
			take_q <= (op_q == OP_TAKE);
			slot_q <= m_head;
			idx_q  <= '0;
			n_q    <= m_cnt;
			if (out_free) begin
				last_q <= 1'b1;
				if (op_q == OP_INSERT && inrange_q && m_cnt != CW'(DEPTH)) begin
					status_q     <= STAT_OK;
					out_id_q     <= id_q;
					out_urgent_q <= urg_q;
					position_q   <= urg_q ? '0 : POS_W'(m_cnt);
				end else begin
					status_q     <= (op_q == OP_INSERT) ? STAT_FULL : STAT_EMPTY;
					out_id_q     <= '0;
					out_urgent_q <= 1'b0;
					position_q   <= '0;
				end
			end
		end else if (state_q == S_READ && out_free) begin
			status_q     <= STAT_OK;
			out_id_q     <= e_rdata[ID_W-1:0];
			out_urgent_q <= e_rdata[ID_W];
			position_q   <= POS_W'(idx_q);
			last_q       <= rd_last;
			slot_q       <= slot_inc;
			idx_q        <= idx_q + CW'(1);
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign out_id     = out_id_q;
	assign out_urgent = out_urgent_q;
	assign position   = position_q;
	assign last       = last_q;

endmodule

### rtl/core/mcpd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the per-queue descriptors and the entry store. No dependencies.
module mcpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
